/* design/majority_over_third_finder_macros.svh */
// Assertion helpers for the majority finder checker
`ifndef MAJORITY_OVER_THIRD_FINDER_MACROS_SVH
`define MAJORITY_OVER_THIRD_FINDER_MACROS_SVH

// same-cycle implication
`define MOF_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MOF_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/mof_pkg.sv */
package mof_pkg;

    localparam int unsigned ValueWidth = 32;

    typedef struct packed {
        logic signed [ValueWidth-1:0] element_value;
        logic                         is_last;
    } in_item_t;

    typedef struct packed {
        logic signed [ValueWidth-1:0] result_value;
        logic                         found;
        logic                         last_result;
    } out_item_t;

    typedef struct packed {
        logic                         valid;
        logic signed [ValueWidth-1:0] value;
    } cand_t;

endpackage

/* design/mof_store.sv */
module mof_store
    import mof_pkg::*;
#(
    parameter int unsigned AddrWidth = 11
)
(
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [AddrWidth-1:0]         wr_addr,
    input  logic signed [ValueWidth-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [AddrWidth-1:0]         rd_addr,
    output logic signed [ValueWidth-1:0] rd_data
);

    localparam int unsigned Depth = 2 ** AddrWidth;

    logic signed [ValueWidth-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* design/mof_jobq.sv */
module mof_jobq
#(
    parameter int unsigned Width = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [Width-1:0] push_data,
    input  logic             pop,
    output logic             empty,
    output logic [Width-1:0] pop_data
);

    logic [Width-1:0] slot_reg [2];
    logic             wp_reg;
    logic             rp_reg;
    logic [1:0]       cnt_reg;

    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

/* design/mof_front.sv */
module mof_front
    import mof_pkg::*;
#(
    parameter int unsigned MaxItems   = 1024,
    parameter int unsigned CountWidth = 11,
    parameter int unsigned IdxWidth   = 10
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  in_item_t                     item,
    input  logic                         done,
    output logic                         job_push,
    output cand_t                        job_one,
    output cand_t                        job_two,
    output logic [CountWidth-1:0]        job_count,
    output logic                         job_bank,
    output logic                         wr_en,
    output logic [IdxWidth:0]            wr_addr,
    output logic signed [ValueWidth-1:0] wr_data
);

    localparam logic [1:0] MaxOutstanding = 2'd2;

    cand_t                 one_reg, one_next;
    cand_t                 two_reg, two_next;
    logic [CountWidth-1:0] vote_one_reg, vote_one_next;
    logic [CountWidth-1:0] vote_two_reg, vote_two_next;
    logic [CountWidth-1:0] count_reg, count_next;
    logic                  bank_reg, bank_next;
    logic [1:0]            credit_reg, credit_next;

    logic accept;

    assign full     = (credit_reg == MaxOutstanding);
    assign accept   = push && !full;
    assign wr_en    = accept && (count_reg < CountWidth'(MaxItems));
    assign wr_addr  = {bank_reg, count_reg[IdxWidth-1:0]};
    assign wr_data  = item.element_value;
    assign job_push = accept && item.is_last;
    assign job_bank = bank_reg;

    always_comb
    begin
        cand_t                 v_one;
        cand_t                 v_two;
        logic [CountWidth-1:0] v_vote_one;
        logic [CountWidth-1:0] v_vote_two;
        logic [CountWidth-1:0] v_count;
        logic                  is_one;
        logic                  is_two;

        v_one      = one_reg;
        v_two      = two_reg;
        v_vote_one = vote_one_reg;
        v_vote_two = vote_two_reg;
        v_count    = count_reg;
        is_one     = one_reg.valid && (one_reg.value == item.element_value);
        is_two     = two_reg.valid && (two_reg.value == item.element_value);

        if (wr_en)
        begin
            v_count = count_reg + CountWidth'(1);
            if (vote_one_reg == '0 && !is_two)
            begin
                v_one      = '{valid: 1'b1, value: item.element_value};
                v_vote_one = CountWidth'(1);
            end
            else if (vote_two_reg == '0 && !is_one)
            begin
                v_two      = '{valid: 1'b1, value: item.element_value};
                v_vote_two = CountWidth'(1);
            end
            else if (is_one)
            begin
                v_vote_one = vote_one_reg + CountWidth'(1);
            end
            else if (is_two)
            begin
                v_vote_two = vote_two_reg + CountWidth'(1);
            end
            else
            begin
                if (vote_one_reg != '0)
                begin
                    v_vote_one = vote_one_reg - CountWidth'(1);
                end
                if (vote_two_reg != '0)
                begin
                    v_vote_two = vote_two_reg - CountWidth'(1);
                end
            end
        end

        job_one   = v_one;
        job_two   = v_two;
        job_count = v_count;

        if (job_push)
        begin
            one_next      = '0;
            two_next      = '0;
            vote_one_next = '0;
            vote_two_next = '0;
            count_next    = '0;
            bank_next     = ~bank_reg;
        end
        else
        begin
            one_next      = v_one;
            two_next      = v_two;
            vote_one_next = v_vote_one;
            vote_two_next = v_vote_two;
            count_next    = v_count;
            bank_next     = bank_reg;
        end

        credit_next = credit_reg + {1'b0, job_push} - {1'b0, done};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_reg      <= '0;
            two_reg      <= '0;
            vote_one_reg <= '0;
            vote_two_reg <= '0;
            count_reg    <= '0;
            bank_reg     <= 1'b0;
            credit_reg   <= 2'd0;
        end
        else
        begin
            one_reg      <= one_next;
            two_reg      <= two_next;
            vote_one_reg <= vote_one_next;
            vote_two_reg <= vote_two_next;
            count_reg    <= count_next;
            bank_reg     <= bank_next;
            credit_reg   <= credit_next;
        end
    end

endmodule

/* design/mof_back.sv */
module mof_back
    import mof_pkg::*;
#(
    parameter int unsigned CountWidth = 11,
    parameter int unsigned IdxWidth   = 10
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         job_empty,
    output logic                         job_pop,
    input  cand_t                        job_one,
    input  cand_t                        job_two,
    input  logic [CountWidth-1:0]        job_count,
    input  logic                         job_bank,
    output logic                         rd_en,
    output logic [IdxWidth:0]            rd_addr,
    input  logic signed [ValueWidth-1:0] rd_data,
    output logic                         done,
    input  logic                         pop,
    output logic                         empty,
    output out_item_t                    result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_TALLY,
        ST_EMIT_ONE,
        ST_EMIT_TWO
    } state_t;

    localparam logic [1:0] OutDepth = 2'd2;

    state_t                state_reg;
    cand_t                 one_reg;
    cand_t                 two_reg;
    logic [CountWidth-1:0] n_reg;
    logic                  bank_reg;
    logic [CountWidth-1:0] idx_reg;
    logic                  pend_reg;
    logic [CountWidth-1:0] hits_one_reg;
    logic [CountWidth-1:0] hits_two_reg;

    out_item_t             ofifo_reg [2];
    logic                  owp_reg;
    logic                  orp_reg;
    logic [1:0]            ocnt_reg;

    logic [CountWidth+1:0] triple_one;
    logic [CountWidth+1:0] triple_two;
    logic [CountWidth+1:0] n_wide;
    logic                  qual_one;
    logic                  qual_two;
    logic                  ofree;
    logic                  opush;
    logic                  opop;
    logic                  emit_go;
    out_item_t             oitem;

    assign job_pop = (state_reg == ST_IDLE) && !job_empty;
    assign rd_en   = (state_reg == ST_WALK);
    assign rd_addr = {bank_reg, idx_reg[IdxWidth-1:0]};

    assign triple_one = {1'b0, hits_one_reg, 1'b0} + {2'b00, hits_one_reg};
    assign triple_two = {1'b0, hits_two_reg, 1'b0} + {2'b00, hits_two_reg};
    assign n_wide     = {2'b00, n_reg};
    assign qual_one   = one_reg.valid && (triple_one > n_wide);
    assign qual_two   = two_reg.valid && (triple_two > n_wide);

    assign ofree  = (ocnt_reg != OutDepth);
    assign empty  = (ocnt_reg == 2'd0);
    assign result = ofifo_reg[orp_reg];
    assign opop   = pop && !empty;

    always_comb
    begin
        opush   = 1'b0;
        emit_go = 1'b0;
        oitem   = '0;
        case (state_reg)
            ST_EMIT_ONE:
            begin
                oitem = '{result_value: one_reg.value, found: 1'b1,
                          last_result: !qual_two};
                opush   = qual_one && ofree;
                emit_go = !qual_one || ofree;
            end
            ST_EMIT_TWO:
            begin
                if (qual_two)
                begin
                    oitem = '{result_value: two_reg.value, found: 1'b1,
                              last_result: 1'b1};
                end
                else
                begin
                    oitem = '{result_value: '0, found: 1'b0, last_result: 1'b1};
                end
                opush   = (qual_two || !qual_one) && ofree;
                emit_go = (!qual_two && qual_one) || ofree;
            end
            default:
            begin
                opush   = 1'b0;
                emit_go = 1'b0;
            end
        endcase
    end

    assign done = (state_reg == ST_EMIT_TWO) && emit_go;

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            one_reg  <= job_one;
            two_reg  <= job_two;
            n_reg    <= job_count;
            bank_reg <= job_bank;
        end
        if (opush)
        begin
            ofifo_reg[owp_reg] <= oitem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
            hits_one_reg <= '0;
            hits_two_reg <= '0;
            owp_reg      <= 1'b0;
            orp_reg      <= 1'b0;
            ocnt_reg     <= 2'd0;
        end
        else
        begin
            pend_reg <= rd_en;
            if (pend_reg)
            begin
                if (one_reg.valid && rd_data == one_reg.value)
                begin
                    hits_one_reg <= hits_one_reg + CountWidth'(1);
                end
                if (two_reg.valid && rd_data == two_reg.value)
                begin
                    hits_two_reg <= hits_two_reg + CountWidth'(1);
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (job_pop)
                    begin
                        hits_one_reg <= '0;
                        hits_two_reg <= '0;
                        idx_reg      <= '0;
                        state_reg    <= (job_count == '0) ? ST_TALLY : ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    idx_reg <= idx_reg + CountWidth'(1);
                    if (idx_reg == n_reg - CountWidth'(1))
                    begin
                        state_reg <= ST_TALLY;
                    end
                end
                ST_TALLY:
                begin
                    state_reg <= ST_EMIT_ONE;
                end
                ST_EMIT_ONE:
                begin
                    if (emit_go)
                    begin
                        state_reg <= ST_EMIT_TWO;
                    end
                end
                ST_EMIT_TWO:
                begin
                    if (emit_go)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (opush)
            begin
                owp_reg <= ~owp_reg;
            end
            if (opop)
            begin
                orp_reg <= ~orp_reg;
            end
            ocnt_reg <= ocnt_reg + {1'b0, opush} - {1'b0, opop};
        end
    end

endmodule

/* design/majority_over_third_finder.sv */
// Channel   Handshake            Payload      Beat
// input     push / full          item         one element, is_last ends the set
// result    pop / empty          result       one candidate, or one not-found beat
//
// Loading takes an element whenever push is high and full is low; the front votes as elements arrive.
// The back verifies a set in steps: job pop, one store read per element, tally, two emit
// steps; loading overlaps it, so the front can take in one set while the back verifies another.
// The store has two banks; full rises only when both hold sets not yet verified.
// Results that are not popped fill the two-entry output buffer; a full buffer holds the back in its emit step.
// Reset clears all control state; store contents are don't-care until written.
module majority_over_third_finder
    import mof_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = 1024
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    input  logic      pop,
    output logic      empty,
    output out_item_t result
);

    localparam int unsigned CountWidth = $clog2(MAX_ITEMS + 1);
    localparam int unsigned IdxWidth   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int unsigned JobWidth   = 2 * $bits(cand_t) + CountWidth + 1;

    logic                         done;
    logic                         f_job_push;
    cand_t                        f_job_one;
    cand_t                        f_job_two;
    logic [CountWidth-1:0]        f_job_count;
    logic                         f_job_bank;
    logic [JobWidth-1:0]          jobq_in;
    logic [JobWidth-1:0]          jobq_out;
    logic                         jobq_empty;
    logic                         jobq_pop;
    cand_t                        b_job_one;
    cand_t                        b_job_two;
    logic [CountWidth-1:0]        b_job_count;
    logic                         b_job_bank;
    logic                         wr_en;
    logic [IdxWidth:0]            wr_addr;
    logic signed [ValueWidth-1:0] wr_data;
    logic                         rd_en;
    logic [IdxWidth:0]            rd_addr;
    logic signed [ValueWidth-1:0] rd_data;

    assign jobq_in = {f_job_bank, f_job_one, f_job_two, f_job_count};
    assign {b_job_bank, b_job_one, b_job_two, b_job_count} = jobq_out;

    mof_front #(
        .MaxItems   (MAX_ITEMS),
        .CountWidth (CountWidth),
        .IdxWidth   (IdxWidth)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .done      (done),
        .job_push  (f_job_push),
        .job_one   (f_job_one),
        .job_two   (f_job_two),
        .job_count (f_job_count),
        .job_bank  (f_job_bank),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    mof_jobq #(
        .Width (JobWidth)
    ) u_jobq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_job_push),
        .push_data (jobq_in),
        .pop       (jobq_pop),
        .empty     (jobq_empty),
        .pop_data  (jobq_out)
    );

    mof_store #(
        .AddrWidth (IdxWidth + 1)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mof_back #(
        .CountWidth (CountWidth),
        .IdxWidth   (IdxWidth)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (jobq_empty),
        .job_pop   (jobq_pop),
        .job_one   (b_job_one),
        .job_two   (b_job_two),
        .job_count (b_job_count),
        .job_bank  (b_job_bank),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .done      (done),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

/* design/mof_checker.sv */
`include "majority_over_third_finder_macros.svh"

module mof_checker
    import mof_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      pop,
    input logic      empty,
    input out_item_t result
);

    // a not-found beat always closes its set
    `MOF_ASSERT_IMP(a_notfound_is_last, !empty && !result.found, result.last_result, "not-found beat without last_result")

    // hold an unpopped result
    `MOF_ASSERT_NXT(a_result_held, !empty && !pop, !empty && $stable(result), "waiting result changed or vanished")

    // a found beat that is not last is followed at once by a distinct closing candidate
    `MOF_ASSERT_NXT(a_second_follows, !empty && pop && result.found && !result.last_result, !empty && result.found && result.last_result && (result.result_value != $past(result.result_value)), "second candidate missing or repeated")

endmodule

bind majority_over_third_finder mof_checker u_mof_checker (.*);

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
    import mof_pkg::*;

    localparam int unsigned MAX_ITEMS = 1024;
    localparam int unsigned RANDOM_ELEMENTS = 430;
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam logic [31:0] MOST_NEGATIVE = 32'h8000_0000;
    localparam logic [31:0] MOST_POSITIVE = 32'h7fff_ffff;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    in_item_t  item = '0;
    logic      pop = 1'b0;
    logic      empty;
    out_item_t result;

    majority_over_third_finder #(
        .MAX_ITEMS(MAX_ITEMS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .item(item),
        .pop(pop),
        .empty(empty),
        .result(result)
    );

    always #4 clk = ~clk;

    in_item_t    pending_elements[$];
    out_item_t   majority_results[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    // track the set being loaded
    logic [31:0] held_elements[MAX_ITEMS];
    logic [31:0] cand_one;
    logic [31:0] cand_two;
    bit          cand_one_ok;
    bit          cand_two_ok;
    int unsigned votes_one;
    int unsigned votes_two;
    int unsigned elem_total;

    task automatic clear_tally();
        cand_one = '0;
        cand_two = '0;
        cand_one_ok = 1'b0;
        cand_two_ok = 1'b0;
        votes_one = 0;
        votes_two = 0;
        elem_total = 0;
    endtask

    task automatic tally_element(input in_item_t beat);
        logic [31:0] v;
        bit          hit_one;
        bit          hit_two;
        bit          qual_one;
        bit          qual_two;
        int unsigned seen_one;
        int unsigned seen_two;
        int unsigned need;
        out_item_t   r;
        v = beat.element_value;
        // drop elements beyond the store depth
        if (elem_total < MAX_ITEMS)
        begin
            held_elements[elem_total] = v;
            elem_total++;
            hit_one = cand_one_ok && cand_one == v;
            hit_two = cand_two_ok && cand_two == v;
            if (votes_one == 0 && !hit_two)
            begin
                cand_one = v;
                cand_one_ok = 1'b1;
                votes_one = 1;
            end
            else if (votes_two == 0 && !hit_one)
            begin
                cand_two = v;
                cand_two_ok = 1'b1;
                votes_two = 1;
            end
            else if (hit_one)
            begin
                votes_one++;
            end
            else if (hit_two)
            begin
                votes_two++;
            end
            else
            begin
                if (votes_one > 0) votes_one--;
                if (votes_two > 0) votes_two--;
            end
        end
        if (beat.is_last)
        begin
            seen_one = 0;
            seen_two = 0;
            for (int unsigned i = 0; i < elem_total; i++)
            begin
                if (cand_one_ok && held_elements[i] == cand_one) seen_one++;
                if (cand_two_ok && held_elements[i] == cand_two) seen_two++;
            end
            need = elem_total / 3 + 1;
            qual_one = cand_one_ok && seen_one >= need;
            qual_two = cand_two_ok && seen_two >= need;
            if (qual_one)
            begin
                r.result_value = cand_one;
                r.found = 1'b1;
                r.last_result = !qual_two;
                majority_results = {majority_results, r};
            end
            if (qual_two)
            begin
                r.result_value = cand_two;
                r.found = 1'b1;
                r.last_result = 1'b1;
                majority_results = {majority_results, r};
            end
            if (!qual_one && !qual_two)
            begin
                r.result_value = '0;
                r.found = 1'b0;
                r.last_result = 1'b1;
                majority_results = {majority_results, r};
            end
            clear_tally();
        end
    endtask

    task automatic add_element(input logic [31:0] v, input bit last);
        in_item_t beat;
        beat.element_value = v;
        beat.is_last = last;
        pending_elements = {pending_elements, beat};
    endtask

    // send in bursts with random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    bit          keep_push;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            keep_push = push;
            if (push && !full)
            begin
                tally_element(item);
                void'(pending_elements.pop_front());
                keep_push = 1'b0;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            if (!keep_push)
            begin
                if (gap_left > 0) gap_left--;
                else if (pending_elements.size() > 0) keep_push = 1'b1;
            end
            push <= keep_push;
            if (keep_push) item <= pending_elements[0];
        end
    end

    // pop in runs with stalls in between
    int unsigned run_left = 0;
    int unsigned stall_left = 0;
    bit          next_pop;
    out_item_t   want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (majority_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected beat: value %0d found %0b last %0b",
                                 result.result_value, result.found, result.last_result);
                end
                else
                begin
                    want = majority_results.pop_front();
                    if (result.result_value !== want.result_value ||
                        result.found !== want.found ||
                        result.last_result !== want.last_result)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: expected value %0d found %0b last %0b, ",
                                      "got value %0d found %0b last %0b"},
                                     want.result_value, want.found, want.last_result,
                                     result.result_value, result.found, result.last_result);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                next_pop = 1'b0;
            end
            else
            begin
                next_pop = 1'b1;
                if (run_left > 0) run_left--;
                else
                begin
                    run_left = $urandom_range(1, 30);
                    case ($urandom_range(0, 7))
                        0, 1:    stall_left = 0;
                        7:       stall_left = $urandom_range(20, 40);
                        default: stall_left = $urandom_range(1, 4);
                    endcase
                end
            end
            pop <= next_pop;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("majority_over_third_finder test failed");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] pool[3];
        logic [31:0] v;
        int unsigned set_len;
        int unsigned style;
        int unsigned random_total;

        clear_tally();

        // single-element sets
        add_element(MOST_NEGATIVE, 1'b1);
        add_element(32'h0, 1'b1);
        // both candidates qualify, extremes of the range
        add_element(MOST_POSITIVE, 1'b0);
        add_element(MOST_POSITIVE, 1'b0);
        add_element(MOST_NEGATIVE, 1'b0);
        add_element(MOST_NEGATIVE, 1'b0);
        add_element(32'd5, 1'b1);
        // nothing qualifies
        add_element(32'd1, 1'b0);
        add_element(32'd2, 1'b0);
        add_element(32'd3, 1'b1);
        // first candidate only
        add_element(32'hffff_ffff, 1'b0);
        add_element(32'hffff_ffff, 1'b0);
        add_element(32'hffff_ffff, 1'b0);
        add_element(32'd7, 1'b1);
        // second candidate only
        add_element(32'd4, 1'b0);
        add_element(32'd9, 1'b0);
        add_element(32'd9, 1'b1);
        // zero is a real value
        add_element(32'h0, 1'b0);
        add_element(32'h0, 1'b0);
        add_element(32'd5, 1'b0);
        add_element(32'd6, 1'b1);

        random_total = 0;
        while (random_total < RANDOM_ELEMENTS)
        begin
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                  : $urandom_range(1, 12);
            style = $urandom_range(0, 3);
            for (int i = 0; i < 3; i++)
            begin
                case ($urandom_range(0, 7))
                    0:       pool[i] = MOST_NEGATIVE;
                    1:       pool[i] = MOST_POSITIVE;
                    2:       pool[i] = 32'h0;
                    3:       pool[i] = 32'hffff_ffff;
                    default: pool[i] = $urandom;
                endcase
            end
            for (int unsigned i = 0; i < set_len; i++)
            begin
                case (style)
                    0:       v = $urandom;
                    1:       v = pool[$urandom_range(0, 2)];
                    2:       v = ($urandom_range(0, 1) == 0) ? pool[0] : $urandom;
                    default: v = ($urandom_range(0, 4) == 0) ? $urandom
                                                             : pool[$urandom_range(0, 1)];
                endcase
                add_element(v, i == set_len - 1);
            end
            random_total += set_len;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (pending_elements.size() > 0 || push) @(posedge clk);
        while (majority_results.size() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("majority_over_third_finder test passed");
        else
            $display("majority_over_third_finder test failed");
        $finish;
    end

endmodule
